// ----- rtl/rrtq_pkg.sv -----
// Shared types for the round-robin task queue: operation and status codes,
// controller states, and the command and status bundles between the controller
// and the datapath. This package has no dependencies.
`timescale 1ns / 1ps

package rrtq_pkg;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_REMOVE,
    OP_PICK,
    OP_SET_BLOCKED
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_IGNORED,
    ST_NONE_RUNNABLE,
    ST_EMPTY
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INS_CLOSE,
    S_REM_WALK,
    S_REM_FIX,
    S_PICK_STEP,
    S_RESULT
  } state_t;

  // Datapath actions, one per cycle.
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_INS_FIRST,
    ACT_INS_LINK,
    ACT_INS_CLOSE,
    ACT_REM_LAST,
    ACT_WALK_INIT,
    ACT_WALK_ADV,
    ACT_REM_UNLINK,
    ACT_PICK_INIT,
    ACT_PICK_ADV,
    ACT_PICK_TAKE,
    ACT_SET_BLK
  } act_t;

  // Address source for the link memory read port.
  typedef enum logic [1:0] {
    RD_HEAD,
    RD_TAIL,
    RD_TID,
    RD_LINK
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    act_t    act;
    rd_sel_t rd_sel;
    logic    finish;
    status_t res;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic bad_id;
    logic queued;
    logic empty;
    logic lone;
    logic found;
    logic eligible;
    logic last_step;
    logic out_busy;
  } dp_sts_t;

endpackage

// ----- rtl/rrtq_ctrl.sv -----
// Controller state machine of the round-robin task queue. It sequences each
// operation through the datapath by commands. Depends on rrtq_pkg.
`timescale 1ns / 1ps

module rrtq_ctrl
  import rrtq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t  state_r, state_nxt;
  status_t res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= ST_OK;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    res_nxt    = res_r;
    cmd.load   = 1'b0;
    cmd.act    = ACT_NONE;
    cmd.rd_sel = RD_HEAD;
    cmd.finish = 1'b0;
    cmd.res    = res_r;
    in_stall   = (state_r != S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.op)
          OP_INSERT: begin
            if (sts.bad_id || sts.queued) begin
              res_nxt   = ST_IGNORED;
              state_nxt = S_RESULT;
            end else if (sts.empty) begin
              cmd.act   = ACT_INS_FIRST;
              res_nxt   = ST_OK;
              state_nxt = S_RESULT;
            end else begin
              cmd.act   = ACT_INS_LINK;
              state_nxt = S_INS_CLOSE;
            end
          end
          OP_REMOVE: begin
            if (sts.bad_id || !sts.queued) begin
              res_nxt   = ST_IGNORED;
              state_nxt = S_RESULT;
            end else if (sts.lone) begin
              cmd.act   = ACT_REM_LAST;
              res_nxt   = ST_OK;
              state_nxt = S_RESULT;
            end else begin
              // The walk starts at the tail, whose link closes the ring.
              cmd.act    = ACT_WALK_INIT;
              cmd.rd_sel = RD_TAIL;
              state_nxt  = S_REM_WALK;
            end
          end
          OP_PICK: begin
            if (sts.empty) begin
              res_nxt   = ST_EMPTY;
              state_nxt = S_RESULT;
            end else begin
              cmd.act    = ACT_PICK_INIT;
              cmd.rd_sel = RD_HEAD;
              state_nxt  = S_PICK_STEP;
            end
          end
          OP_SET_BLOCKED: begin
            if (sts.bad_id) begin
              res_nxt = ST_IGNORED;
            end else begin
              cmd.act = ACT_SET_BLK;
              res_nxt = ST_OK;
            end
            state_nxt = S_RESULT;
          end
          default: state_nxt = S_RESULT;
        endcase
      end
      S_INS_CLOSE: begin
        cmd.act   = ACT_INS_CLOSE;
        res_nxt   = ST_OK;
        state_nxt = S_RESULT;
      end
      S_REM_WALK: begin
        if (sts.found) begin
          cmd.rd_sel = RD_TID;
          state_nxt  = S_REM_FIX;
        end else begin
          cmd.act    = ACT_WALK_ADV;
          cmd.rd_sel = RD_LINK;
        end
      end
      S_REM_FIX: begin
        cmd.act   = ACT_REM_UNLINK;
        res_nxt   = ST_OK;
        state_nxt = S_RESULT;
      end
      S_PICK_STEP: begin
        if (sts.eligible) begin
          cmd.act   = ACT_PICK_TAKE;
          res_nxt   = ST_OK;
          state_nxt = S_RESULT;
        end else if (sts.last_step) begin
          // A full pass leaves the ring exactly where it started.
          res_nxt   = ST_NONE_RUNNABLE;
          state_nxt = S_RESULT;
        end else begin
          cmd.act    = ACT_PICK_ADV;
          cmd.rd_sel = RD_LINK;
        end
      end
      S_RESULT: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_DECODE)
    else $error("load did not lead to decode");

  a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> state_r == S_IDLE && !in_stall)
    else $error("finish did not return to idle");

  a_pick_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PICK_STEP && sts.eligible |=> res_r == ST_OK)
    else $error("eligible pick not reported as ok");

endmodule

// ----- rtl/rrtq_datapath.sv -----
// Datapath of the round-robin task queue: the circular link memory, queued and
// blocked flags, head, tail and count registers, walk pointer and the output
// register. Driven by rrtq_ctrl through rrtq_pkg command and status types.
`timescale 1ns / 1ps

module rrtq_datapath
  import rrtq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] in_operation,
  input  logic [5:0] in_task_id,
  input  logic       in_blocked_value,
  input  logic [5:0] in_current_task,
  input  logic       out_stall,
  output logic       out_valid,
  output logic [5:0] out_chosen_task,
  output logic [1:0] out_status,
  output logic [6:0] out_queue_length,
  input  dp_cmd_t    cmd,
  output dp_sts_t    sts
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [6:0]       DepthL = 7'(DEPTH);
  localparam logic [CNT_W-1:0] CntOne = CNT_W'(1);
  localparam logic [CNT_W-1:0] CntMax = CNT_W'(DEPTH);

  op_t              op_r;
  logic [5:0]       tid_r;
  logic             bval_r;
  logic [5:0]       cur_r;
  logic [IDX_W-1:0] head_r, tail_r, walk_r, chosen_r;
  logic [CNT_W-1:0] count_r, step_r;
  logic [DEPTH-1:0] queued_r, blocked_r;

  // While the queue is not empty the links form a ring: the tail links to the head.
  logic [IDX_W-1:0] link_mem [DEPTH];
  logic [IDX_W-1:0] rd_q;
  logic [IDX_W-1:0] rd_addr, wr_addr, wr_data;
  logic             wr_en;

  logic             out_valid_r;
  logic [5:0]       out_chosen_r;
  status_t          out_status_r;
  logic [6:0]       out_len_r;

  logic [IDX_W-1:0] tid_idx;

  assign tid_idx = tid_r[IDX_W-1:0];

  always_comb begin
    case (cmd.rd_sel)
      RD_HEAD: rd_addr = head_r;
      RD_TAIL: rd_addr = tail_r;
      RD_TID:  rd_addr = tid_idx;
      default: rd_addr = rd_q;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = tid_idx;
    wr_data = tid_idx;
    case (cmd.act)
      ACT_INS_FIRST: begin
        wr_en = 1'b1;
      end
      ACT_INS_LINK: begin
        wr_en   = 1'b1;
        wr_addr = tail_r;
      end
      ACT_INS_CLOSE: begin
        wr_en   = 1'b1;
        wr_data = head_r;
      end
      ACT_REM_UNLINK: begin
        wr_en   = 1'b1;
        wr_addr = walk_r;
        wr_data = rd_q;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    rd_q <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(in_operation);
      tid_r  <= in_task_id;
      bval_r <= in_blocked_value;
      cur_r  <= in_current_task;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      queued_r  <= '0;
      blocked_r <= '0;
    end else begin
      case (cmd.act)
        ACT_INS_FIRST: begin
          head_r            <= tid_idx;
          tail_r            <= tid_idx;
          queued_r[tid_idx] <= 1'b1;
          count_r           <= count_r + CntOne;
        end
        ACT_INS_CLOSE: begin
          tail_r            <= tid_idx;
          queued_r[tid_idx] <= 1'b1;
          count_r           <= count_r + CntOne;
        end
        ACT_REM_LAST: begin
          queued_r[tid_idx] <= 1'b0;
          count_r           <= count_r - CntOne;
        end
        ACT_REM_UNLINK: begin
          if (head_r == tid_idx) begin
            head_r <= rd_q;
          end
          if (tail_r == tid_idx) begin
            tail_r <= walk_r;
          end
          queued_r[tid_idx] <= 1'b0;
          count_r           <= count_r - CntOne;
        end
        ACT_PICK_TAKE: begin
          head_r <= rd_q;
          tail_r <= walk_r;
        end
        ACT_SET_BLK: begin
          blocked_r[tid_idx] <= bval_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.act)
      ACT_WALK_INIT: walk_r <= tail_r;
      ACT_WALK_ADV:  walk_r <= rd_q;
      ACT_PICK_INIT: begin
        walk_r <= head_r;
        step_r <= '0;
      end
      ACT_PICK_ADV: begin
        walk_r <= rd_q;
        step_r <= step_r + CntOne;
      end
      default: begin
      end
    endcase
    if (cmd.load) begin
      chosen_r <= '0;
    end else if (cmd.act == ACT_PICK_TAKE) begin
      chosen_r <= walk_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_chosen_r <= 6'(chosen_r);
      out_status_r <= cmd.res;
      out_len_r    <= 7'(count_r);
    end
  end

  always_comb begin
    sts.op        = op_r;
    sts.bad_id    = {1'b0, tid_r} >= DepthL;
    sts.queued    = queued_r[tid_idx];
    sts.empty     = (count_r == '0);
    sts.lone      = (count_r == CntOne);
    sts.found     = (rd_q == tid_idx);
    sts.eligible  = !blocked_r[walk_r] && ((6'(walk_r) != cur_r) || (count_r == CntOne));
    sts.last_step = (step_r == count_r - CntOne);
    sts.out_busy  = out_valid_r && out_stall;
  end

  assign out_valid        = out_valid_r;
  assign out_chosen_task  = out_chosen_r;
  assign out_status       = out_status_r;
  assign out_queue_length = out_len_r;

  a_count_flags: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(queued_r) == count_r)
    else $error("task count differs from number of queued flags");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntMax)
    else $error("task count above depth");

  a_lone_ring: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CntOne |-> head_r == tail_r)
    else $error("single queued task but head and tail differ");

  a_first_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.act == ACT_INS_FIRST |-> count_r == '0)
    else $error("first insert on a non-empty queue");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_valid_r && out_stall))
    else $error("result loaded over one still waiting");

endmodule

// ----- rtl/round_robin_task_queue.sv -----
// Top level of the round-robin task queue: joins the controller and the
// datapath. Depends on rrtq_pkg, rrtq_ctrl and rrtq_datapath.
//
//  Channel  Direction  Payload                                        Transfer
//  in_      input      operation, task_id, blocked_value, current_task valid & !stall
//  out_     output     chosen_task, status, queue_length              valid & !stall
//
// One item is worked on at a time; a new one is taken in the cycle after the
// previous result has been loaded into the output register.
// Insert, set-blocked, ignored requests, a pick on an empty queue and removal of
// the only queued task walk no links; any other pick or remove may walk the ring,
// fewer links than the queue length, one link per cycle through the registered
// read port.
// Reset clears the flags, head, tail and count at once; there is no clearing pass.
// A stalled result holds in the output register; the next item is still taken
// and waits for the register before its own result is loaded.
`timescale 1ns / 1ps

module round_robin_task_queue
  import rrtq_pkg::*;
#(
  parameter int MAX_TASKS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [5:0] in_task_id,
  input  logic       in_blocked_value,
  input  logic [5:0] in_current_task,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_chosen_task,
  output logic [1:0] out_status,
  output logic [6:0] out_queue_length
);

  // Task ids are six bits wide, so no more than 64 entries can ever be used.
  localparam int DEPTH = (MAX_TASKS < 64) ? MAX_TASKS : 64;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rrtq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrtq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_operation     (in_operation),
    .in_task_id       (in_task_id),
    .in_blocked_value (in_blocked_value),
    .in_current_task  (in_current_task),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_chosen_task  (out_chosen_task),
    .out_status       (out_status),
    .out_queue_length (out_queue_length),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for round_robin_task_queue: a scoreboard class keeps its
// own copy of the ready queue and the blocked bits and predicts every result.
// Depends on rrtq_pkg and the round_robin_task_queue RTL.
`timescale 1ns / 1ps

module testbench;
  import rrtq_pkg::*;

  localparam int NUM_IDS = 64;
  localparam int RANDOM_ITEMS = 1200;
  localparam int SEGMENT = 150;
  localparam int DRAIN_EVERY = 300;
  localparam int IDLE_LIMIT = 3000;
  localparam int TAIL_CYCLES = 80;

  typedef struct {
    op_t        op;
    logic [5:0] tid;
    logic       bval;
    logic [5:0] cur;
  } request_t;

  typedef struct {
    logic [5:0] chosen;
    status_t    status;
    logic [6:0] length;
  } outcome_t;

  class task_queue_scoreboard;
    logic [5:0] order[$];
    bit         queued[NUM_IDS];
    bit         blocked[NUM_IDS];
    outcome_t   awaited[$];
    int         errors;

    function int pending();
      return awaited.size();
    endfunction

    // Works out the result of one accepted request and updates the queue copy.
    function void note_input(request_t r);
      outcome_t   o;
      logic [5:0] h;
      int         n;
      int         i;
      o.chosen = '0;
      o.status = ST_OK;
      case (r.op)
        OP_INSERT: begin
          if (queued[r.tid]) begin
            o.status = ST_IGNORED;
          end else begin
            order.push_back(r.tid);
            queued[r.tid] = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (!queued[r.tid]) begin
            o.status = ST_IGNORED;
          end else begin
            for (i = 0; i < order.size(); i++) begin
              if (order[i] == r.tid) begin
                order.delete(i);
                break;
              end
            end
            queued[r.tid] = 1'b0;
          end
        end
        OP_PICK: begin
          n = order.size();
          if (n == 0) begin
            o.status = ST_EMPTY;
          end else begin
            // Each step moves the head to the tail, so a fruitless full pass
            // leaves the order as it was.
            o.status = ST_NONE_RUNNABLE;
            for (i = 0; i < n; i++) begin
              h = order.pop_front();
              order.push_back(h);
              if (!blocked[h] && (h != r.cur || n == 1)) begin
                o.status = ST_OK;
                o.chosen = h;
                break;
              end
            end
          end
        end
        default: begin
          blocked[r.tid] = r.bval;
        end
      endcase
      o.length = 7'(order.size());
      awaited.push_back(o);
    endfunction

    function void check_result(logic [5:0] chosen, logic [1:0] status, logic [6:0] length);
      outcome_t e;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with nothing awaited: chosen %0d status %0d length %0d",
                 $time, chosen, status, length);
        return;
      end
      e = awaited.pop_front();
      if (chosen !== e.chosen) begin
        errors++;
        $display("%0t: chosen_task expected %0d, got %0d", $time, e.chosen, chosen);
      end
      if (status !== e.status) begin
        errors++;
        $display("%0t: status expected %0d, got %0d", $time, e.status, status);
      end
      if (length !== e.length) begin
        errors++;
        $display("%0t: queue_length expected %0d, got %0d", $time, e.length, length);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_operation = '0;
  logic [5:0] in_task_id = '0;
  logic       in_blocked_value = 1'b0;
  logic [5:0] in_current_task = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [5:0] out_chosen_task;
  logic [1:0] out_status;
  logic [6:0] out_queue_length;

  task_queue_scoreboard sb = new();

  round_robin_task_queue uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_task_id       (in_task_id),
    .in_blocked_value (in_blocked_value),
    .in_current_task  (in_current_task),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_chosen_task  (out_chosen_task),
    .out_status       (out_status),
    .out_queue_length (out_queue_length)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver back-pressure: runs of free flow, light stalls, heavy stalls and
  // solid stalls, each lasting a random number of cycles.
  int stall_mode = 0;
  int stall_run = 0;
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_run <= (stall_mode == 0) ? $urandom_range(1, 30) : $urandom_range(20, 200);
      out_stall <= 1'b0;
    end else begin
      stall_run <= stall_run - 1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_chosen_task, out_status, out_queue_length);
    end
  end

  // Ends the run if no transfer happens on either channel for too long.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic request_t req(op_t op, int tid, bit bval, int cur);
    request_t r;
    r.op = op;
    r.tid = 6'(tid);
    r.bval = bval;
    r.cur = 6'(cur);
    return r;
  endfunction

  // Lowers valid and holds the sender until every awaited result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    request_t   directed[$];
    request_t   r;
    int         free_ids[$];
    int         total;
    int         burst_left;
    int         roll;
    int         n;
    bit         grow;

    // Empty queue, absent tasks, a lone task, skipping the current task, all
    // tasks blocked, and removal from the head and the middle.
    directed.push_back(req(OP_PICK, 0, 1'b0, 0));
    directed.push_back(req(OP_REMOVE, 5, 1'b0, 0));
    directed.push_back(req(OP_SET_BLOCKED, 63, 1'b1, 0));
    directed.push_back(req(OP_INSERT, 63, 1'b0, 0));
    directed.push_back(req(OP_PICK, 0, 1'b0, 63));
    directed.push_back(req(OP_SET_BLOCKED, 63, 1'b0, 0));
    directed.push_back(req(OP_PICK, 0, 1'b0, 63));
    directed.push_back(req(OP_INSERT, 63, 1'b0, 0));
    directed.push_back(req(OP_INSERT, 0, 1'b0, 0));
    directed.push_back(req(OP_INSERT, 42, 1'b0, 0));
    directed.push_back(req(OP_INSERT, 21, 1'b0, 0));
    directed.push_back(req(OP_PICK, 0, 1'b0, 63));
    directed.push_back(req(OP_SET_BLOCKED, 42, 1'b1, 0));
    directed.push_back(req(OP_PICK, 0, 1'b0, 21));
    directed.push_back(req(OP_SET_BLOCKED, 0, 1'b1, 0));
    directed.push_back(req(OP_SET_BLOCKED, 63, 1'b1, 0));
    directed.push_back(req(OP_SET_BLOCKED, 21, 1'b1, 0));
    directed.push_back(req(OP_PICK, 0, 1'b0, 0));
    directed.push_back(req(OP_REMOVE, 42, 1'b0, 0));
    directed.push_back(req(OP_SET_BLOCKED, 21, 1'b0, 0));
    directed.push_back(req(OP_REMOVE, 0, 1'b0, 0));
    directed.push_back(req(OP_PICK, 0, 1'b0, 63));
    directed.push_back(req(OP_REMOVE, 63, 1'b0, 0));
    directed.push_back(req(OP_REMOVE, 21, 1'b0, 0));
    directed.push_back(req(OP_SET_BLOCKED, 0, 1'b0, 63));

    total = directed.size() + RANDOM_ITEMS;
    burst_left = $urandom_range(1, 24);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < total; n++) begin
      if (n == directed.size() || (n > 0 && n % DRAIN_EVERY == 0)) begin
        drain_results();
      end else if (burst_left <= 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(1, 24);
      end

      if (n < directed.size()) begin
        r = directed[n];
      end else begin
        // Phases alternate between filling and emptying the queue, so that
        // both the empty and the full queue are reached.
        grow = ((n / SEGMENT) % 2) == 0;
        roll = $urandom_range(0, 99);
        r.bval = ($urandom_range(0, 9) < 3);
        r.tid = 6'($urandom_range(0, NUM_IDS - 1));
        if (sb.order.size() > 0 && $urandom_range(0, 9) < 6) begin
          r.cur = sb.order[$urandom_range(0, sb.order.size() - 1)];
        end else begin
          r.cur = 6'($urandom_range(0, NUM_IDS - 1));
        end
        if (roll < (grow ? 50 : 5)) begin
          r.op = OP_INSERT;
          free_ids.delete();
          for (int id = 0; id < NUM_IDS; id++) begin
            if (!sb.queued[id]) free_ids.push_back(id);
          end
          if (free_ids.size() > 0 && $urandom_range(0, 9) != 0) begin
            r.tid = 6'(free_ids[$urandom_range(0, free_ids.size() - 1)]);
          end
        end else if (roll < 55) begin
          r.op = OP_REMOVE;
          if (sb.order.size() > 0 && $urandom_range(0, 9) != 0) begin
            r.tid = sb.order[$urandom_range(0, sb.order.size() - 1)];
          end
        end else if (roll < 85) begin
          r.op = OP_PICK;
        end else begin
          r.op = OP_SET_BLOCKED;
          if (sb.order.size() > 0 && $urandom_range(0, 9) < 7) begin
            r.tid = sb.order[$urandom_range(0, sb.order.size() - 1)];
          end
        end
      end

      in_valid <= 1'b1;
      in_operation <= r.op;
      in_task_id <= r.tid;
      in_blocked_value <= r.bval;
      in_current_task <= r.cur;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      sb.note_input(r);
      burst_left--;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
